[hdl/sai_pkg.sv]
// ----------------------------------------------------------------------------
// sai_pkg: shared types and codes for the sorted array insert block
// Item kinds, status codes, fixed field widths and the cell control bundle.
// ----------------------------------------------------------------------------
package sai_pkg;

   // fixed field widths
   localparam int KIND_W = 2;
   localparam int SLOT_W = 6;
   localparam int STAT_W = 2;
   localparam int POS_W  = 7;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic cmp_en;    // register the compare flag against the broadcast key
      logic shift_en;  // apply the insert: take new key or the left neighbor
   } cell_ctrl_type;

endpackage

[hdl/sai_cell.sv]
// ----------------------------------------------------------------------------
// sai_cell: one storage cell of the insertion chain
// Holds one key, compares it with the broadcast key and on an insert either
// keeps it, takes the new key or takes its left neighbor's key.
// ----------------------------------------------------------------------------
module sai_cell
   import sai_pkg::*;
#(
   parameter int KEY_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [KEY_WIDTH-1:0] new_key,
   input  logic [KEY_WIDTH-1:0] left_key,
   input  logic                 left_gt,
   input  logic                 valid,
   output logic [KEY_WIDTH-1:0] key_q,
   output logic                 gt_q,
   output logic                 take_new
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic                 gt_ff;
   logic                 gt_in;

   // an empty cell counts as greater than any key
   always_comb begin
      gt_in = gt_ff;
      if (ctrl.cmp_en) begin
         gt_in = !valid || ($signed(key_ff) > $signed(new_key));
      end
   end

   // first greater cell takes the new key, cells above it shift up by one
   assign take_new = gt_ff && !left_gt;

   always_comb begin
      key_in = key_ff;
      if (ctrl.shift_en) begin
         if (take_new) begin
            key_in = new_key;
         end else if (left_gt) begin
            key_in = left_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gt_ff <= 1'b0;
      end else begin
         gt_ff <= gt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_q = key_ff;
   assign gt_q  = gt_ff;

endmodule

[hdl/sorted_array_insert.sv]
// ----------------------------------------------------------------------------
// sorted_array_insert: sorted key array with insert, read and clear
// Keeps up to CAPACITY signed keys in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per item: kind in req_tuser, key and slot
//   in req_tdata. rsp_* returns exactly one transaction per item: status in
//   rsp_tuser, position, read value and fill in rsp_tdata.
//   An insert places the key after all stored keys that are not greater,
//   so equal keys keep arrival order; an insert into a full array is dropped
//   with status full. A read past the fill returns status range and zero.
//   A clear empties the array.
// Timing:
//   An item goes through three steps: accept, compare in every cell at once,
//   then update the chain and load the result register. The result appears
//   on rsp_* the cycle after that; a new item is accepted only once the
//   previous one has left the update step. The compare flags of the cells
//   must settle in a register before the chain shifts, hence separate steps.
// Reset and stall:
//   Reset empties the array and drops any pending result. A new item is
//   accepted while a result waits; if the receiver stalls, the update waits
//   for the result register to free up and holds the following item.
// ----------------------------------------------------------------------------
module sorted_array_insert
   import sai_pkg::*;
#(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // kind
   input  logic [KIND_W-1:0]    req_tuser,
   // key, slot, zero padding
   input  logic [((KEY_WIDTH + SLOT_W + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // status
   output logic [STAT_W-1:0]    rsp_tuser,
   // position, read_value, fill, zero padding
   output logic [((POS_W + KEY_WIDTH + POS_W + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int OUT_W = ((POS_W + KEY_WIDTH + POS_W + 7) / 8) * 8;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [KEY_WIDTH-1:0] rdval_ff, rdval_in;
   logic                 rdok_ff, rdok_in;

   logic                 out_valid_ff, out_valid_in;
   logic [STAT_W-1:0]    out_stat_ff, out_stat_in;
   logic [POS_W-1:0]     out_pos_ff, out_pos_in;
   logic [KEY_WIDTH-1:0] out_val_ff, out_val_in;
   logic [POS_W-1:0]     out_fill_ff, out_fill_in;

   logic                 accept;
   logic                 finish;
   logic                 full;
   cell_ctrl_type        ctrl;

   logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0]  cell_gt;
   logic [CAPACITY-1:0]  cell_take;
   logic [IDX_W-1:0]     ins_pos;

   assign accept = req_tvalid && req_tready;
   assign finish = (state_ff == S_DONE) && (!out_valid_ff || rsp_tready);
   assign full   = (count_ff == CNT_W'(CAPACITY));

   assign ctrl.cmp_en   = (state_ff == S_CMP);
   assign ctrl.shift_en = finish && (kind_ff == KIND_INSERT) && !full;

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key;
      logic                 left_gt;
      logic                 valid;
      if (i == 0) begin : g_first
         assign left_key = key_ff;
         assign left_gt  = 1'b0;
      end else begin : g_rest
         assign left_key = cell_key[i-1];
         assign left_gt  = cell_gt[i-1];
      end
      assign valid = (CNT_W'(i) < count_ff);
      sai_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .new_key  (key_ff),
         .left_key (left_key),
         .left_gt  (left_gt),
         .valid    (valid),
         .key_q    (cell_key[i]),
         .gt_q     (cell_gt[i]),
         .take_new (cell_take[i])
      );
   end

   // encode the one cell that takes the new key
   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         ins_pos = ins_pos | (cell_take[i] ? IDX_W'(i) : '0);
      end
   end

   // read lookup during the compare cycle
   always_comb begin
      rdval_in = rdval_ff;
      rdok_in  = rdok_ff;
      if (state_ff == S_CMP) begin
         rdok_in  = (CNT_W'(slot_ff) < count_ff) && (32'(slot_ff) < CAPACITY);
         rdval_in = cell_key[IDX_W'(slot_ff)];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (finish) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   // count update and result build
   always_comb begin
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_stat_in  = out_stat_ff;
      out_pos_in   = out_pos_ff;
      out_val_in   = out_val_ff;
      out_fill_in  = out_fill_ff;
      if (finish) begin
         out_valid_in = 1'b1;
         out_stat_in  = STAT_OK;
         out_pos_in   = '0;
         out_val_in   = '0;
         case (kind_ff)
            KIND_INSERT: begin
               if (full) begin
                  out_stat_in = STAT_FULL;
                  out_pos_in  = POS_W'(count_ff);
               end else begin
                  count_in   = count_ff + 1'b1;
                  out_pos_in = POS_W'(ins_pos);
               end
            end
            KIND_READ: begin
               out_pos_in = POS_W'(slot_ff);
               if (rdok_ff) begin
                  out_val_in = rdval_ff;
               end else begin
                  out_stat_in = STAT_RANGE;
               end
            end
            KIND_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
         out_fill_in = POS_W'(count_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_tuser;
         key_ff  <= req_tdata[KEY_WIDTH-1:0];
         slot_ff <= req_tdata[KEY_WIDTH +: SLOT_W];
      end
      rdval_ff    <= rdval_in;
      rdok_ff     <= rdok_in;
      out_stat_ff <= out_stat_in;
      out_pos_ff  <= out_pos_in;
      out_val_ff  <= out_val_in;
      out_fill_ff <= out_fill_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_stat_ff;
   assign rsp_tdata  = OUT_W'({out_fill_ff, out_val_ff, out_pos_ff});

   // fill never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // an accepted insert into a non-full array lands in exactly one cell
   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift_en |-> $onehot(cell_take))
      else $error("insert position not unique");

   // a good insert grows the count by one
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count not advanced after insert");

   // result register loads only at the end of an item
   a_load_end: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff && out_valid_in) |-> (state_ff == S_DONE))
      else $error("result loaded outside the update cycle");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted array insert block
// Streams insert, read, clear and unknown-kind items into the block. Every
// accepted item goes through a shadow copy of the sorted array, and each
// response is compared field by field with the oldest prediction. Both
// sides idle at random, and the receiver holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb;
   import sai_pkg::*;

   localparam int CAP   = 64;
   localparam int KEY_W = 32;
   localparam int IN_W  = ((KEY_W + SLOT_W + 7) / 8) * 8;
   localparam int OUT_W = ((2 * POS_W + KEY_W + 7) / 8) * 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 24;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT_RSP  = 300;
   localparam int RANDOM_ITEMS = 800;

   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

   typedef struct {
      logic [KIND_W-1:0]       kind;
      logic signed [KEY_W-1:0] key;
      logic [SLOT_W-1:0]       slot;
      bit                      drain;   // wait for all responses before offering
   } req_item_type;

   typedef struct {
      logic [STAT_W-1:0]       status;
      logic [POS_W-1:0]        position;
      logic signed [KEY_W-1:0] read_value;
      logic [POS_W-1:0]        fill;
   } rsp_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [KIND_W-1:0] req_tuser = '0;   // kind
   logic [IN_W-1:0]  req_tdata = '0;    // key, slot, zero padding
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [STAT_W-1:0] rsp_tuser;        // status
   logic [OUT_W-1:0] rsp_tdata;         // position, read_value, fill, zero padding

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];

   // shadow copy of the array and its fill
   logic signed [KEY_W-1:0] shadow_keys[CAP];
   int shadow_fill = 0;

   int errors = 0;
   int cycles = 0;
   int gen_fill = 0;
   int gap_left = 0;
   int burst_left = 0;
   int rsp_seen = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int mon_cyc = 0;

   sorted_array_insert #(
      .CAPACITY  (CAP),
      .KEY_WIDTH (KEY_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Apply one accepted item to the shadow array and queue its response.
   task automatic apply_to_shadow(input logic [KIND_W-1:0] kind,
                                  input logic signed [KEY_W-1:0] key,
                                  input logic [SLOT_W-1:0] slot);
      rsp_item_type r;
      int idx;
      int j;
      r.status     = STAT_OK;
      r.position   = '0;
      r.read_value = '0;
      case (kind)
         KIND_INSERT: begin
            if (shadow_fill >= CAP) begin
               r.status   = STAT_FULL;
               r.position = POS_W'(shadow_fill);
            end else begin
               // first stored key strictly greater than the new one
               idx = 0;
               while (idx < shadow_fill && !(shadow_keys[idx] > key)) idx++;
               for (j = shadow_fill; j > idx; j--) shadow_keys[j] = shadow_keys[j-1];
               shadow_keys[idx] = key;
               shadow_fill++;
               r.position = POS_W'(idx);
            end
         end
         KIND_READ: begin
            r.position = POS_W'(slot);
            if (int'(slot) < shadow_fill) r.read_value = shadow_keys[slot];
            else r.status = STAT_RANGE;
         end
         KIND_CLEAR: begin
            shadow_fill = 0;
         end
         default: ;
      endcase
      r.fill = POS_W'(shadow_fill);
      expected_rsps.push_back(r);
   endtask

   task automatic add_req(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                          input logic [SLOT_W-1:0] slot, input bit drain);
      req_item_type t;
      t.kind  = kind;
      t.key   = key;
      t.slot  = slot;
      t.drain = drain;
      pending_reqs.push_back(t);
      if (kind == KIND_INSERT && gen_fill < CAP) gen_fill++;
      else if (kind == KIND_CLEAR) gen_fill = 0;
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key(input int mode);
      logic signed [KEY_W-1:0] k;
      k = $urandom;
      if (mode == 1) begin
         k = $signed($urandom_range(0, 8)) - 4;
      end else if (mode == 2) begin
         case ($urandom_range(0, 4))
            0: k = {1'b1, {(KEY_W-1){1'b0}}};
            1: k = {1'b0, {(KEY_W-1){1'b1}}};
            2: k = '0;
            3: k = '1;
            default: k = 1;
         endcase
      end
      return k;
   endfunction

   function automatic logic [SLOT_W-1:0] pick_slot();
      if (gen_fill > 0 && $urandom_range(0, 3) != 0)
         return SLOT_W'($urandom_range(0, gen_fill - 1));
      return SLOT_W'($urandom);
   endfunction

   // Stimulus, reset release and end of run
   initial begin
      int n;
      int mode;
      int r;
      int phase;
      int total;
      int insert_pct;

      // directed: extremes, duplicates, every kind, range and unknown cases
      add_req(KIND_READ,    0, 6'd0, 0);
      add_req(KIND_INSERT,  {1'b0, {(KEY_W-1){1'b1}}}, 6'd0, 0);
      add_req(KIND_INSERT,  {1'b1, {(KEY_W-1){1'b0}}}, 6'd63, 0);
      add_req(KIND_INSERT,  0, 6'd0, 0);
      add_req(KIND_INSERT,  -1, 6'd0, 0);
      add_req(KIND_INSERT,  0, 6'd0, 0);
      add_req(KIND_INSERT,  1, 6'd0, 0);
      for (int i = 0; i < 6; i++) add_req(KIND_READ, '1, SLOT_W'(i), 0);
      add_req(KIND_READ,    0, 6'd6, 0);
      add_req(KIND_READ,    0, 6'd63, 0);
      add_req(KIND_UNKNOWN, '1, 6'd63, 0);
      add_req(KIND_UNKNOWN, 0, 6'd0, 0);
      add_req(KIND_CLEAR,   '1, 6'd63, 0);
      add_req(KIND_READ,    0, 6'd0, 0);
      add_req(KIND_INSERT,  -5, 6'd0, 0);
      // pause the sender until the block has drained
      add_req(KIND_CLEAR,   0, 6'd0, 1);

      // random: mostly clear-then-fill runs, some loose noise
      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         r = (phase == 0) ? 5 : $urandom_range(0, 9);
         if (r <= 5) begin
            mode = $urandom_range(0, 2);
            if (r == 5) begin
               n = $urandom_range(70, 80);
               insert_pct = 92;
            end else begin
               n = $urandom_range(1, 20);
               insert_pct = 65;
            end
            add_req(KIND_CLEAR, pick_key(0), SLOT_W'($urandom), ($urandom_range(0, 5) == 0));
            total++;
            for (int i = 0; i < n; i++) begin
               int c;
               c = $urandom_range(0, 99);
               if (c < insert_pct)
                  add_req(KIND_INSERT, pick_key(mode), SLOT_W'($urandom), 0);
               else if (c < 97)
                  add_req(KIND_READ, pick_key(0), pick_slot(), 0);
               else
                  add_req(($urandom_range(0, 1) != 0) ? KIND_UNKNOWN : KIND_CLEAR,
                          pick_key(0), SLOT_W'($urandom), 0);
               total++;
            end
            // read back part of the run
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               add_req(KIND_READ, pick_key(0), pick_slot(), 0);
               total++;
            end
         end else begin
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++) begin
               add_req(KIND_W'($urandom_range(0, 3)), pick_key(0), SLOT_W'($urandom), 0);
               total++;
            end
         end
         phase++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0)
         report($sformatf("%0d responses never arrived", expected_rsps.size()));

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Driver: predict on each accepted transaction, then offer the next item
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            apply_to_shadow(req_tuser, req_tdata[KEY_W-1:0], req_tdata[KEY_W+SLOT_W-1:KEY_W]);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain && expected_rsps.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               req_item_type nxt;
               nxt = pending_reqs.pop_front();
               req_tuser  <= nxt.kind;
               req_tdata  <= IN_W'({nxt.slot, nxt.key});
               req_tvalid <= 1'b1;
               // end the burst and draw the next gap
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Monitor: check each response transaction and set the receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         mon_cyc++;
         if (rsp_tvalid && rsp_tready) begin
            rsp_item_type got;
            rsp_item_type exp_rsp;
            got.status     = rsp_tuser;
            got.position   = rsp_tdata[POS_W-1:0];
            got.read_value = rsp_tdata[POS_W+KEY_W-1:POS_W];
            got.fill       = rsp_tdata[2*POS_W+KEY_W-1:POS_W+KEY_W];
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               report($sformatf("response %0d with no item waiting", rsp_seen));
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (got.status !== exp_rsp.status)
                  report($sformatf("rsp %0d status %0d, want %0d",
                                   rsp_seen, got.status, exp_rsp.status));
               if (got.position !== exp_rsp.position)
                  report($sformatf("rsp %0d position %0d, want %0d",
                                   rsp_seen, got.position, exp_rsp.position));
               if (got.read_value !== exp_rsp.read_value)
                  report($sformatf("rsp %0d read_value %0d, want %0d",
                                   rsp_seen, got.read_value, exp_rsp.read_value));
               if (got.fill !== exp_rsp.fill)
                  report($sformatf("rsp %0d fill %0d, want %0d",
                                   rsp_seen, got.fill, exp_rsp.fill));
            end
         end
         // hold off once for a long stretch so the block backs up
         if (!hold_done && rsp_seen >= HOLD_AT_RSP) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case ((mon_cyc / 97) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ((mon_cyc % 5) < 3);
            endcase
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
